// ----- hw/rtl/sad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_pkg
// Shared types and constants for the sprite attribute decoder.
// ----------------------------------------------------------------------------
package sad_pkg;

    localparam int MAX_HEIGHT_LOG2 = 3;
    localparam int SPAN_W          = (MAX_HEIGHT_LOG2 > 0) ? MAX_HEIGHT_LOG2 : 1;

    localparam int CODE_W   = 16;
    localparam int COLOUR_W = 5;
    localparam int SX_W     = 10;
    localparam int SY_W     = 11;

    localparam logic [9:0]  X_WRAP_LIMIT = 10'd320;
    localparam logic [9:0]  WRAP_SPAN    = 10'd512;
    localparam logic signed [10:0] X_MIRROR   = 11'sd304;
    localparam logic signed [10:0] Y_MIRROR   = 11'sd240;
    localparam logic signed [10:0] X_RIGHT_MAX = 11'sd320;
    localparam int TILE_SHIFT = 4;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [CODE_W-1:0]         tile_base;
        logic [SPAN_W-1:0]         span;
        logic [COLOUR_W-1:0]       colour;
        logic                      flip_x;
        logic                      flip_y;
        logic                      vflip;
        logic                      step_down;
        logic signed [SX_W-1:0]    pos_x;
        logic signed [SY_W-1:0]    pos_y;
    } cmd_t;

endpackage

// ----- hw/rtl/sad_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_front
// Holds the flip register, decodes an entry and classifies it as kept or
// dropped; kept entries become one draw command.
// ----------------------------------------------------------------------------
module sad_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    input  logic [15:0]         attr_word,
    input  logic [15:0]         code_word,
    input  logic [15:0]         pos_word,
    input  logic                frame_odd,
    output logic                keep,
    output sad_pkg::cmd_t       cmd
);
    import sad_pkg::*;

    logic                   flip_reg;
    logic [1:0]             hcode_raw;
    logic [1:0]             hcode;
    logic [SPAN_W-1:0]      span;
    logic [9:0]             x9;
    logic signed [10:0]     x9_ext;
    logic signed [10:0]     y9_ext;
    logic signed [10:0]     xm;
    logic signed [10:0]     ym;
    logic [CODE_W-1:0]      span_ext;
    logic [CODE_W-1:0]      aligned;
    logic                   fx;
    logic                   fy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            flip_reg <= cfg_data;
        end
    end

    always_comb
    begin
        hcode_raw = attr_word[10:9];
        if (32'(hcode_raw) > MAX_HEIGHT_LOG2)
        begin
            hcode = 2'(MAX_HEIGHT_LOG2);
        end
        else
        begin
            hcode = hcode_raw;
        end
        span     = SPAN_W'((32'd1 << hcode) - 32'd1);
        span_ext = CODE_W'(span);

        if ({1'b0, pos_word[8:0]} >= X_WRAP_LIMIT)
        begin
            x9 = {1'b0, pos_word[8:0]} - WRAP_SPAN;
        end
        else
        begin
            x9 = {1'b0, pos_word[8:0]};
        end
        x9_ext = {x9[9], x9};
        y9_ext = {{2{attr_word[8]}}, attr_word[8:0]};
        xm     = X_MIRROR - x9_ext;
        ym     = Y_MIRROR - y9_ext;

        keep = (code_word != '0) && !(attr_word[12] && frame_odd) && !(xm > X_RIGHT_MAX);

        fx = attr_word[13];
        fy = attr_word[14];

        aligned = code_word & ~span_ext;
        cmd.tile_base = fy ? aligned : (aligned + span_ext);
        cmd.span      = span;
        cmd.colour    = pos_word[13:9];
        cmd.vflip     = fy;
        cmd.step_down = !flip_reg;
        if (!flip_reg)
        begin
            cmd.flip_x = !fx;
            cmd.flip_y = !fy;
            cmd.pos_x  = x9;
            cmd.pos_y  = y9_ext;
        end
        else
        begin
            cmd.flip_x = fx;
            cmd.flip_y = fy;
            cmd.pos_x  = xm[SX_W-1:0];
            cmd.pos_y  = ym;
        end
    end

endmodule

// ----- hw/rtl/sad_cmd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_cmd_queue
// Short command queue between the decode front and the tile issue back.
// ----------------------------------------------------------------------------
module sad_cmd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sad_pkg::cmd_t       wr_cmd,
    input  logic                pop,
    output sad_pkg::cmd_t       rd_cmd,
    output logic                full,
    output logic                empty
);
    import sad_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- hw/rtl/sad_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_back
// Walks the head command one tile per cycle into the output register while
// out_stall is low.
module sad_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sad_pkg::cmd_t               cmd,
    input  logic                        cmd_empty,
    output logic                        cmd_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [15:0]                 tile_code,
    output logic [4:0]                  colour_bank,
    output logic                        flip_x,
    output logic                        flip_y,
    output logic signed [9:0]           screen_x,
    output logic signed [10:0]          screen_y,
    output logic                        last_piece
);
    import sad_pkg::*;

    logic [SPAN_W-1:0]      piece_reg;
    logic [SPAN_W-1:0]      piece_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   load;
    logic [SPAN_W-1:0]      k;
    logic [CODE_W-1:0]      k_ext;
    logic signed [SY_W-1:0] dy;
    logic [CODE_W-1:0]      tile_calc;
    logic signed [SY_W-1:0] sy_calc;
    logic                   last_calc;

    logic [CODE_W-1:0]      tile_reg;
    logic [COLOUR_W-1:0]    colour_reg;
    logic                   fx_reg;
    logic                   fy_reg;
    logic signed [SX_W-1:0] sx_reg;
    logic signed [SY_W-1:0] sy_reg;
    logic                   last_reg;

    always_comb
    begin
        load      = !cmd_empty && (!valid_reg || !out_stall);
        k         = cmd.span - piece_reg;
        k_ext     = CODE_W'(k);
        last_calc = (k == '0);
        tile_calc = cmd.vflip ? (cmd.tile_base + k_ext) : (cmd.tile_base - k_ext);
        dy        = SY_W'({k, TILE_SHIFT'(0)});
        sy_calc   = cmd.step_down ? (cmd.pos_y + dy) : (cmd.pos_y - dy);
        cmd_pop   = load && last_calc;

        piece_next = piece_reg;
        if (load)
        begin
            piece_next = last_calc ? '0 : piece_reg + 1'b1;
        end

        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            piece_reg <= piece_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tile_reg   <= tile_calc;
            colour_reg <= cmd.colour;
            fx_reg     <= cmd.flip_x;
            fy_reg     <= cmd.flip_y;
            sx_reg     <= cmd.pos_x;
            sy_reg     <= sy_calc;
            last_reg   <= last_calc;
        end
    end

    assign out_valid   = valid_reg;
    assign tile_code   = tile_reg;
    assign colour_bank = colour_reg;
    assign flip_x      = fx_reg;
    assign flip_y      = fy_reg;
    assign screen_x    = sx_reg;
    assign screen_y    = sy_reg;
    assign last_piece  = last_reg;

endmodule

// ----- hw/rtl/sprite_attribute_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_attribute_decoder_core
// Decodes a three-word sprite entry into a column of 16x16 tile draw words.
//
//   channel  | handshake              | word
//   ---------+------------------------+------------------------------------------
//   in       | in_valid / in_stall    | attr_word, code_word, pos_word, frame_odd
//   out      | out_valid / out_stall  | tile_code .. last_piece
//   cfg      | cfg_valid / cfg_ready  | screen_flip_control
//
// A kept entry issues 1, 2, 4 or 8 words, one per cycle from the issue unit
// while out_stall is low; a dropped entry is taken at the input and never queued.
// A two-deep command queue lets decode run ahead of issue; in_stall rises
// when the queue is full. Output is registered and holds under out_stall.
// After reset the flip register reads 0. No clearing pass.
// ----------------------------------------------------------------------------
module sprite_attribute_decoder_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         attr_word,
    input  logic [15:0]         code_word,
    input  logic [15:0]         pos_word,
    input  logic                frame_odd,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                screen_flip_control,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         tile_code,
    output logic [4:0]          colour_bank,
    output logic                flip_x,
    output logic                flip_y,
    output logic signed [9:0]   screen_x,
    output logic signed [10:0]  screen_y,
    output logic                last_piece
);
    import sad_pkg::*;

    cmd_t       front_cmd;
    cmd_t       head_cmd;
    logic       keep;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign q_push    = in_valid && !q_full && keep;

    sad_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (screen_flip_control),
        .attr_word  (attr_word),
        .code_word  (code_word),
        .pos_word   (pos_word),
        .frame_odd  (frame_odd),
        .keep       (keep),
        .cmd        (front_cmd)
    );

    sad_cmd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_cmd     (front_cmd),
        .pop        (q_pop),
        .rd_cmd     (head_cmd),
        .full       (q_full),
        .empty      (q_empty)
    );

    sad_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .cmd_empty   (q_empty),
        .cmd_pop     (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tile_code   (tile_code),
        .colour_bank (colour_bank),
        .flip_x      (flip_x),
        .flip_y      (flip_y),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .last_piece  (last_piece)
    );

endmodule

// ----- hw/rtl/sad_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_checker
// Port-level checks for the sprite attribute decoder.
// ----------------------------------------------------------------------------
module sad_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [15:0]         tile_code,
    input  logic [4:0]          colour_bank,
    input  logic                flip_x,
    input  logic                flip_y,
    input  logic signed [9:0]   screen_x,
    input  logic                last_piece
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tile_code))
        else $error("output word dropped or changed under stall");

    // pieces of one sprite follow back to back with shared attributes
    a_piece_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_piece |=> out_valid)
        else $error("gap inside a sprite column");

    a_piece_attr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_piece |=>
            colour_bank == $past(colour_bank) && flip_x == $past(flip_x) &&
            flip_y == $past(flip_y))
        else $error("sprite attributes changed within a column");

    a_piece_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_piece |=> screen_x == $past(screen_x))
        else $error("x position changed within a column");

endmodule

bind sprite_attribute_decoder_core sad_checker u_sad_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tile_code   (tile_code),
    .colour_bank (colour_bank),
    .flip_x      (flip_x),
    .flip_y      (flip_y),
    .screen_x    (screen_x),
    .last_piece  (last_piece)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sprite_attribute_decoder_core. A script of sprite
// entries, drain points and flip register writes feeds a clocked driver. Each
// accepted entry is expanded into its column of tile words by a local model
// and queued. A clocked monitor applies random back-pressure and checks every
// word it takes field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module tb_top;

    import sad_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ENTRIES  = 50;

    typedef enum logic [1:0] {STEP_ENTRY, STEP_DRAIN, STEP_FLIP} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic [15:0] attr;
        logic [15:0] code;
        logic [15:0] pos;
        logic        odd;
        logic        flip;
        int unsigned gap;
    } script_step_t;

    typedef struct packed {
        logic [15:0]        tile;
        logic [4:0]         colour;
        logic               fx;
        logic               fy;
        logic signed [9:0]  sx;
        logic signed [10:0] sy;
        logic               last;
    } tile_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        attr_word = '0;
    logic [15:0]        code_word = '0;
    logic [15:0]        pos_word = '0;
    logic               frame_odd = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               screen_flip_control = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        tile_code;
    logic [4:0]         colour_bank;
    logic               flip_x;
    logic               flip_y;
    logic signed [9:0]  screen_x;
    logic signed [10:0] screen_y;
    logic               last_piece;

    script_step_t script[$];
    tile_word_t   tile_words_due[$];

    logic flip_setting = 1'b0;
    int   gap_cnt = 0;
    int   settle_cnt = 0;
    int   stall_left = 0;
    int   free_left = 0;
    int   idle_cycles = 0;
    int   n_errors = 0;
    int   n_entries = 0;
    int   n_dropped = 0;
    int   n_words = 0;
    int   n_flip_writes = 0;

    sprite_attribute_decoder_core dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .attr_word           (attr_word),
        .code_word           (code_word),
        .pos_word            (pos_word),
        .frame_odd           (frame_odd),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .screen_flip_control (screen_flip_control),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .tile_code           (tile_code),
        .colour_bank         (colour_bank),
        .flip_x              (flip_x),
        .flip_y              (flip_y),
        .screen_x            (screen_x),
        .screen_y            (screen_y),
        .last_piece          (last_piece)
    );

    always #5 clk = ~clk;

    // Expand one entry into the tile words it should produce
    task automatic expand_entry(input logic [15:0] attr, input logic [15:0] code,
                                input logic [15:0] pos, input logic odd);
        int          hgt;
        int          span_n;
        int          x9;
        int          y9;
        int          sx;
        int          sy;
        int          sy_k;
        int          pitch;
        int          k;
        logic [15:0] span;
        logic [15:0] base;
        logic        fx;
        logic        fy;
        logic        vflip;
        tile_word_t  w;
        n_entries++;
        if (code == 16'h0000 || (attr[12] && odd))
        begin
            n_dropped++;
            return;
        end
        hgt = int'(attr[10:9]);
        if (hgt > MAX_HEIGHT_LOG2)
            hgt = MAX_HEIGHT_LOG2;
        span_n = (1 << hgt) - 1;
        span = 16'(span_n);
        x9 = int'(pos[8:0]);
        y9 = int'(attr[8:0]);
        if (x9 >= 320)
            x9 -= 512;
        if (y9 >= 256)
            y9 -= 512;
        sx = 304 - x9;
        sy = 240 - y9;
        if (sx > 320)
        begin
            n_dropped++;
            return;
        end
        fx = attr[13];
        fy = attr[14];
        vflip = fy;
        base = code & ~span;
        if (!vflip)
            base = base + span;
        if (!flip_setting)
        begin
            sx = x9;
            sy = y9;
            fx = !fx;
            fy = !fy;
            pitch = 16;
        end
        else
        begin
            pitch = -16;
        end
        for (k = span_n; k >= 0; k--)
        begin
            sy_k = sy + pitch * k;
            w.tile = vflip ? base + 16'(k) : base - 16'(k);
            w.colour = pos[13:9];
            w.fx = fx;
            w.fy = fy;
            w.sx = sx[9:0];
            w.sy = sy_k[10:0];
            w.last = (k == 0);
            tile_words_due.push_back(w);
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            n_errors++;
        end
    endtask

    task automatic add_entry(input logic [15:0] attr, input logic [15:0] code,
                             input logic [15:0] pos, input logic odd, input int unsigned gap);
        script_step_t s;
        s.kind = STEP_ENTRY;
        s.attr = attr;
        s.code = code;
        s.pos = pos;
        s.odd = odd;
        s.flip = 1'b0;
        s.gap = gap;
        script.push_back(s);
    endtask

    task automatic add_barrier(input step_kind_t kind, input logic flip);
        script_step_t s;
        s.kind = kind;
        s.attr = '0;
        s.code = '0;
        s.pos = '0;
        s.odd = 1'b0;
        s.flip = flip;
        s.gap = 0;
        script.push_back(s);
    endtask

    // Driver: presents entries, waits for drain before barriers and flip writes
    always @(posedge clk or negedge rst_n)
    begin : drive_seq
        logic hold_valid;
        logic hold_cfg;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            gap_cnt = 0;
            settle_cnt = 0;
        end
        else
        begin
            hold_valid = in_valid;
            hold_cfg = cfg_valid;
            if (in_valid && !in_stall)
            begin
                expand_entry(attr_word, code_word, pos_word, frame_odd);
                hold_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                flip_setting = screen_flip_control;
                n_flip_writes++;
                hold_cfg = 1'b0;
            end
            if (!hold_valid && !hold_cfg && script.size() != 0)
            begin
                if (script[0].kind == STEP_ENTRY)
                begin
                    if (gap_cnt < int'(script[0].gap))
                    begin
                        gap_cnt++;
                    end
                    else
                    begin
                        attr_word <= script[0].attr;
                        code_word <= script[0].code;
                        pos_word <= script[0].pos;
                        frame_odd <= script[0].odd;
                        hold_valid = 1'b1;
                        gap_cnt = 0;
                        void'(script.pop_front());
                    end
                end
                else if (tile_words_due.size() != 0)
                begin
                    settle_cnt = 0;
                end
                else if (settle_cnt < SETTLE_CYCLES)
                begin
                    settle_cnt++;
                end
                else
                begin
                    settle_cnt = 0;
                    if (script[0].kind == STEP_FLIP)
                    begin
                        screen_flip_control <= script[0].flip;
                        hold_cfg = 1'b1;
                    end
                    void'(script.pop_front());
                end
            end
            in_valid <= hold_valid;
            cfg_valid <= hold_cfg;
        end
    end

    // Monitor: random back-pressure and per-field checking of each tile word
    always @(posedge clk or negedge rst_n)
    begin : watch_out
        tile_word_t exp_w;
        int         r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            free_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tile_words_due.size() == 0)
                begin
                    $display("%0t ns: unexpected tile word, expected none, got tile %0d",
                             $time, tile_code);
                    n_errors++;
                end
                else
                begin
                    exp_w = tile_words_due.pop_front();
                    n_words++;
                    check_field("tile_code", int'(exp_w.tile), int'(tile_code));
                    check_field("colour_bank", int'(exp_w.colour), int'(colour_bank));
                    check_field("flip_x", int'(exp_w.fx), int'(flip_x));
                    check_field("flip_y", int'(exp_w.fy), int'(flip_y));
                    check_field("screen_x", int'(exp_w.sx), int'(screen_x));
                    check_field("screen_y", int'(exp_w.sy), int'(screen_y));
                    check_field("last_piece", int'(exp_w.last), int'(last_piece));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (free_left > 0)
            begin
                free_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    free_left = $urandom_range(1, 40);
                else if (r < 88)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(10, 40);
            end
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
                $display("[sprite_attribute_decoder_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : main_seq
        logic [15:0] attr;
        logic [15:0] code;
        logic [15:0] pos;
        logic        odd;
        logic        calm;
        int          r;
        int unsigned gap;
        int          ph;
        int          i;

        // directed entries under the reset flip value
        add_entry(16'h0010, 16'h0000, 16'h0010, 1'b0, 0);  // empty slot
        add_entry(16'h1000, 16'h0001, 16'h0000, 1'b1, 0);  // flashing, odd frame
        add_entry(16'h1000, 16'h0005, 16'h0000, 1'b0, 0);  // flashing, even frame
        add_entry(16'h0220, 16'h0123, 16'h0100, 1'b0, 0);
        add_entry(16'h4440, 16'h0456, 16'h0040, 1'b1, 1);
        add_entry(16'h66ff, 16'h0789, 16'h3f3f, 1'b0, 0);  // x 319, y 255, bank 31
        add_entry(16'h0700, 16'hffff, 16'h01ff, 1'b0, 0);  // y 256, x 511
        add_entry(16'h0000, 16'h0001, 16'h0140, 1'b0, 0);  // x 320: off right edge
        add_entry(16'h0600, 16'h0010, 16'h01f0, 1'b0, 0);  // right edge exactly
        add_entry(16'h0000, 16'h0001, 16'h01ef, 1'b0, 2);  // one past right edge
        add_entry(16'h01ff, 16'h0200, 16'h0000, 1'b0, 0);  // y 511
        add_entry(16'h8a00, 16'h0101, 16'hc020, 1'b1, 0);  // unused bits set
        add_entry(16'hffff, 16'hffff, 16'hffff, 1'b0, 0);
        add_entry(16'hffff, 16'hffff, 16'hffff, 1'b1, 0);
        add_entry(16'h2400, 16'h8000, 16'h1e80, 1'b0, 0);
        add_entry(16'h0600, 16'h0001, 16'h0000, 1'b0, 0);

        for (ph = 0; ph < 7; ph++)
        begin
            add_barrier(STEP_FLIP, (ph % 2 == 0));
            calm = (ph % 3 == 1);
            for (i = 0; i < PHASE_ENTRIES; i++)
            begin
                if (i == PHASE_ENTRIES / 2 && (ph == 2 || ph == 5))
                    add_barrier(STEP_DRAIN, 1'b0);
                attr = 16'($urandom);
                code = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
                pos = 16'($urandom);
                odd = 1'($urandom_range(0, 1));
                // mostly keep x on screen so the entry produces tiles
                if ($urandom_range(0, 3) != 0)
                    pos[8:0] = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(496, 511))
                                                           : 9'($urandom_range(0, 319));
                r = $urandom_range(0, 99);
                if (calm || r < 60)
                    gap = 0;
                else if (r < 92)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(12, 40);
                add_entry(attr, code, pos, odd, gap);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (script.size() != 0 || in_valid || cfg_valid || tile_words_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tile_words_due.size() != 0)
        begin
            $display("%0t ns: %0d tile words never arrived", $time, tile_words_due.size());
            n_errors++;
        end
        $display("Sprite entries: %0d sent, %0d dropped; tile words checked: %0d.",
                 n_entries, n_dropped, n_words);
        $display("Flip register writes: %0d, both settings, with random gaps and stalls.",
                 n_flip_writes);
        if (n_errors == 0)
            $display("[sprite_attribute_decoder_core] OK");
        else
            $display("[sprite_attribute_decoder_core] ERROR");
        $finish;
    end

endmodule
